// ----- rtl/core/ipcr_pkg.sv -----
// ipcr_pkg: shared types and constants for the ir pulse capture and replay unit
// used by ipcr_ctrl, ipcr_dp and ir_pulse_capture_replay_unit; no dependencies
`default_nettype none

package ipcr_pkg;

    // default number of interval slots in the store
    localparam int SLOTS_DEFAULT = 64;

    // fixed field widths
    localparam int STAMP_W    = 32;
    localparam int RATE_W     = 24;
    localparam int TIMEOUT_W  = 20;
    localparam int TOTAL_W    = 7;
    localparam int PERIODS_W  = 32;
    localparam int RATE_FRAC  = 24;
    localparam int PROD_W     = STAMP_W + RATE_W;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_REPLAY = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // result item kinds
    typedef enum logic {
        RES_CAPTURE = 1'b0,
        RES_PULSE   = 1'b1
    } res_kind_t;

    // configuration register indexes
    typedef enum logic {
        CFG_RATE    = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_index_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIN_WAIT,
        ST_READ,
        ST_MUL,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic do_edge;
        logic do_tick;
        logic rep_start;
        logic rd_en;
        logic mul_en;
        logic emit_load;
        logic fin_load;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic edge_finishes;
        logic tick_finishes;
        logic rep_empty;
        logic rep_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipcr_ctrl.sv -----
// ipcr_ctrl: sequencing state machine for capture, result hand-off and replay
// depends on ipcr_pkg
`default_nettype none

module ipcr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic [1:0]            s_tuser,
    output logic                       s_tready,
    input  wire ipcr_pkg::dp_status_t  status,
    output ipcr_pkg::ctrl_cmd_t        cmd
);
    import ipcr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    kind_t  kind;

    assign kind   = kind_t'(s_tuser);
    assign accept = s_tvalid && (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_EDGE:
                        begin
                            if (status.edge_finishes)
                            begin
                                state_next = ST_FIN_WAIT;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (status.tick_finishes)
                            begin
                                state_next = ST_FIN_WAIT;
                            end
                        end
                        KIND_REPLAY:
                        begin
                            if (!status.rep_empty)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIN_WAIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.rep_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.do_edge   = accept && (kind == KIND_EDGE);
        cmd.do_tick   = accept && (kind == KIND_TICK);
        cmd.rep_start = accept && (kind == KIND_REPLAY);
        case (state_reg)
            ST_FIN_WAIT:
            begin
                cmd.fin_load = status.out_free;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_load = status.out_free;
            end
            default:
            begin
                cmd.fin_load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipcr_dp.sv -----
// ipcr_dp: capture registers, interval store, period scaling and output register
// depends on ipcr_pkg; driven by ipcr_ctrl commands
`default_nettype none

module ipcr_dp #(
    parameter int PULSE_SLOTS = ipcr_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ipcr_pkg::ctrl_cmd_t            cmd,
    output ipcr_pkg::dp_status_t                status,
    input  wire logic [ipcr_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [ipcr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ipcr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import ipcr_pkg::*;

    localparam int ADDR_W  = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(PULSE_SLOTS + 1);
    localparam int ENTRY_W = STAMP_W + 1;

    // configuration
    logic [RATE_W-1:0]    rate_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // capture state
    logic [CNT_W-1:0]     count_reg;
    logic [STAMP_W-1:0]   prev_reg;
    logic [TIMEOUT_W-1:0] left_reg;
    logic                 armed_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     final_reg;

    // replay pipeline
    logic [ADDR_W-1:0]    addr_reg;
    logic [ENTRY_W-1:0]   rdata_reg;
    logic                 rd_last_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 carrier_reg;
    logic                 mul_last_reg;

    // output register
    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic                 out_carrier_reg;
    logic [PERIODS_W-1:0] out_periods_reg;
    logic                 out_last_reg;

    logic [ENTRY_W-1:0]   store [PULSE_SLOTS];

    logic [STAMP_W-1:0]   stamp;
    logic                 rising;
    logic                 full;
    logic                 store_wr;
    logic                 edge_fin;
    logic                 tick_fin;
    logic                 finish;
    logic                 out_free;

    assign stamp    = s_tdata[STAMP_W-1:0];
    assign rising   = s_tdata[STAMP_W];
    assign full     = (count_reg >= CNT_W'(PULSE_SLOTS));
    assign edge_fin = !done_reg && full;
    assign tick_fin = !done_reg && armed_reg && (left_reg <= TIMEOUT_W'(1));
    assign store_wr = cmd.do_edge && !done_reg && !full;
    assign finish   = (cmd.do_edge && edge_fin) || (cmd.do_tick && tick_fin);
    assign out_free = !out_valid_reg || m_tready;

    // status to controller
    always_comb
    begin
        status.edge_finishes = edge_fin;
        status.tick_finishes = tick_fin;
        status.rep_empty     = (final_reg <= CNT_W'(1));
        status.rep_last      = mul_last_reg;
        status.out_free      = out_free;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= RATE_W'(50995);
            timeout_reg <= TIMEOUT_W'(100000);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RATE:    rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default:     rate_reg    <= rate_reg;
            endcase
        end
    end

    // capture state update for edges and ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prev_reg  <= '0;
            left_reg  <= '0;
            armed_reg <= 1'b0;
            done_reg  <= 1'b0;
            final_reg <= '0;
        end
        else if (finish)
        begin
            final_reg <= count_reg;
            count_reg <= '0;
            done_reg  <= 1'b1;
            armed_reg <= 1'b0;
            left_reg  <= '0;
        end
        else if (store_wr)
        begin
            prev_reg  <= stamp;
            count_reg <= count_reg + CNT_W'(1);
            left_reg  <= timeout_reg;
            armed_reg <= 1'b1;
        end
        else if (cmd.do_tick && !done_reg && armed_reg)
        begin
            left_reg <= left_reg - TIMEOUT_W'(1);
        end
    end

    // interval store, registered read
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store[count_reg[ADDR_W-1:0]] <= {rising, stamp - prev_reg};
        end
        if (cmd.rd_en)
        begin
            rdata_reg   <= store[addr_reg];
            rd_last_reg <= (CNT_W'(addr_reg) + CNT_W'(1)) == final_reg;
        end
    end

    // replay address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.rep_start)
        begin
            addr_reg <= ADDR_W'(1);
        end
        else if (cmd.emit_load)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
    end

    // width times carrier rate; the top bits never exceed 32 bits
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg     <= PROD_W'(rdata_reg[STAMP_W-1:0]) * PROD_W'(rate_reg);
            carrier_reg  <= rdata_reg[STAMP_W];
            mul_last_reg <= rd_last_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.fin_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.fin_load)
        begin
            out_kind_reg    <= RES_CAPTURE;
            out_total_reg   <= TOTAL_W'(final_reg);
            out_carrier_reg <= 1'b0;
            out_periods_reg <= '0;
            out_last_reg    <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_kind_reg    <= RES_PULSE;
            out_total_reg   <= '0;
            out_carrier_reg <= carrier_reg;
            out_periods_reg <= prod_reg[RATE_FRAC +: PERIODS_W];
            out_last_reg    <= mul_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_periods_reg, out_carrier_reg, out_total_reg};

endmodule

`default_nettype wire

// ----- rtl/core/ir_pulse_capture_replay_unit.sv -----
// ir pulse capture and replay: edges and ticks that do not end the capture leave s_tready high;
// a capture end drops s_tready until its result is loaded and m_tvalid raised.
// a replay drops s_tready and passes each pulse through store read, multiply and output
// register in turn; the next store read waits until the pulse before it has been loaded.
// rst_n clears control state and returns configuration to its defaults; store not cleared.
// depends on ipcr_pkg, ipcr_ctrl and ipcr_dp
`default_nettype none

module ir_pulse_capture_replay_unit #(
    parameter int PULSE_SLOTS = ipcr_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ipcr_pkg::S_DATA_W-1:0]   s_tdata,  // edge_stamp[31:0], rise_flag[32]
    input  wire logic [1:0]                      s_tuser,  // kind[1:0]
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ipcr_pkg::M_DATA_W-1:0]        m_tdata,  // pulse_total[6:0], carrier_on[7],
                                                           // carrier_periods[39:8]
    output logic                                 m_tuser,  // result_kind[0]
    output logic                                 m_tlast,
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [ipcr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ipcr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    ipcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    ipcr_dp #(
        .PULSE_SLOTS (PULSE_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// testbench for ir_pulse_capture_replay_unit: one capture of edges and ticks, then many replays
// under changing carrier rates, each result item checked against a cycle-free behavioural shadow
// depends on ipcr_pkg and the rtl under rtl/core
`default_nettype none

module testbench;
    import ipcr_pkg::*;

    localparam int SLOTS         = 64;
    localparam int ITEM_TARGET   = 460;
    localparam int CALM_ITEMS    = 60;
    localparam int SETTLE_CYC    = 8;
    localparam int TAIL_CYC      = 40;
    localparam int RATE_RESET    = 50995;
    localparam int TIMEOUT_RESET = 100000;
    localparam longint LIMIT_T   = 64'd15_000_000;

    typedef struct {
        kind_t       kind;
        logic [31:0] stamp;
        logic        rising;
    } ir_item_t;

    typedef struct {
        res_kind_t                rk;
        logic [TOTAL_W-1:0]       total;
        logic                     carrier;
        logic [PERIODS_W-1:0]     periods;
        logic                     last;
    } ir_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the capture store, timer and registers
    logic [32:0]          sh_store [SLOTS];
    int unsigned          sh_count;
    int unsigned          sh_left;
    int unsigned          sh_final;
    logic [31:0]          sh_prev;
    bit                   sh_armed;
    bit                   sh_done;
    logic [RATE_W-1:0]    sh_rate;
    logic [TIMEOUT_W-1:0] sh_timeout;

    ir_result_t results_due[$];
    ir_item_t   pending[$];
    ir_item_t   shown_item;
    int         in_shown;
    int         in_taken;
    int         send_gap;
    int         recv_stall;
    bit         calm;
    int         errors;

    ir_pulse_capture_replay_unit #(
        .PULSE_SLOTS(SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    endtask

    // capture end: latch the count, stop the timer, report the total
    task automatic close_capture();
        ir_result_t r;
        sh_final = sh_count;
        sh_count = 0;
        sh_done  = 1'b1;
        sh_armed = 1'b0;
        sh_left  = 0;
        r.rk      = RES_CAPTURE;
        r.total   = sh_final[TOTAL_W-1:0];
        r.carrier = 1'b0;
        r.periods = '0;
        r.last    = 1'b0;
        results_due.push_back(r);
    endtask

    // expected results of one accepted input item
    task automatic model_ir_item(input ir_item_t it);
        ir_result_t  r;
        logic [63:0] scaled;
        case (it.kind)
            KIND_EDGE:
            begin
                if (!sh_done)
                begin
                    sh_armed = 1'b0;
                    if (sh_count >= SLOTS)
                        close_capture();
                    else
                    begin
                        sh_store[sh_count % SLOTS] = {it.rising, it.stamp - sh_prev};
                        sh_prev  = it.stamp;
                        sh_count++;
                        sh_left  = sh_timeout;
                        sh_armed = 1'b1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (!sh_done && sh_armed)
                begin
                    if (sh_left <= 1)
                        close_capture();
                    else
                        sh_left--;
                end
            end
            KIND_REPLAY:
            begin
                for (int unsigned i = 1; i < sh_final; i++)
                begin
                    scaled = {32'd0, sh_store[i][31:0]} * {40'd0, sh_rate};
                    r.rk      = RES_PULSE;
                    r.total   = '0;
                    r.carrier = sh_store[i][32];
                    r.periods = ((scaled >> RATE_FRAC) > 64'hFFFF_FFFF) ? '1
                                                                       : scaled[55:24];
                    r.last    = (i + 1 == sh_final);
                    results_due.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // input acceptance feeds the shadow
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            model_ir_item(shown_item);
            in_taken++;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        ir_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
                report_mismatch("unexpected result item, tdata", m_tdata, 64'd0);
            else
            begin
                want = results_due.pop_front();
                if (m_tuser !== want.rk)
                    report_mismatch("result_kind", m_tuser, want.rk);
                if (m_tdata[6:0] !== want.total)
                    report_mismatch("pulse_total", m_tdata[6:0], want.total);
                if (m_tdata[7] !== want.carrier)
                    report_mismatch("carrier_on", m_tdata[7], want.carrier);
                if (m_tdata[39:8] !== want.periods)
                    report_mismatch("carrier_periods", m_tdata[39:8], want.periods);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // sender: next pending item once the shown one is taken, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken == in_shown))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                shown_item = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_DATA_W-STAMP_W-1){1'b0}}, shown_item.rising, shown_item.stamp};
                s_tuser  <= shown_item.kind;
                in_shown++;
                if (!calm && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: ready with random stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    recv_stall = $urandom_range(1, 7);
            end
        end
    end

    task automatic push_item(input kind_t k, input logic [31:0] st, input logic r);
        ir_item_t it;
        it.kind   = k;
        it.stamp  = st;
        it.rising = r;
        pending.push_back(it);
    endtask

    // everything sent, taken and delivered, then a settle wait for work with no result
    task automatic wait_quiet();
        while (pending.size() != 0 || in_taken != in_shown || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_RATE)
            sh_rate = val[RATE_W-1:0];
        else
            sh_timeout = val[TIMEOUT_W-1:0];
    endtask

    // reset and stimulus
    initial
    begin : stimulus
        int          counted;
        int          edges_goal;
        int unsigned end_to;
        int unsigned gen_to;
        int unsigned n_ticks;
        logic [31:0] gen_prev;
        logic [31:0] st;
        logic [CFG_DATA_W-1:0] val;
        int          phase;
        int          burst;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_RATE;
        cfg_data   = '0;
        in_shown   = 0;
        in_taken   = 0;
        send_gap   = 0;
        recv_stall = 0;
        calm       = 1'b0;
        errors     = 0;
        sh_count   = 0;
        sh_left    = 0;
        sh_final   = 0;
        sh_prev    = '0;
        sh_armed   = 1'b0;
        sh_done    = 1'b0;
        sh_rate    = RATE_W'(RATE_RESET);
        sh_timeout = TIMEOUT_W'(TIMEOUT_RESET);
        rst_n      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening: tick with timer disarmed, replay before capture end,
        // unused kind, stamp extremes giving widths of zero, all ones and a wrap
        push_item(KIND_TICK, $urandom, 1'b1);
        push_item(KIND_REPLAY, $urandom, 1'b0);
        push_item(KIND_NONE, $urandom, 1'b1);
        push_item(KIND_EDGE, 32'h0000_0000, 1'b0);
        push_item(KIND_EDGE, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_EDGE, 32'hFFFF_FFFF, 1'b0);
        push_item(KIND_EDGE, 32'h0000_0000, 1'b1);
        push_item(KIND_TICK, 32'h0000_0000, 1'b0);
        push_item(KIND_REPLAY, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_NONE, 32'h0000_0000, 1'b0);
        counted  = 10;
        gen_prev = 32'h0000_0000;

        // capture ends on a full store, or by timeout after fewer edges
        edges_goal = ($urandom_range(0, 1) == 1) ? SLOTS : $urandom_range(5, SLOTS - 1);
        end_to     = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 8);
        wait_quiet();
        write_reg(CFG_TIMEOUT, 24'hFF_FFFF);
        gen_to = 20'hF_FFFF;
        for (int e = 5; e <= edges_goal; e++)
        begin
            if (e == edges_goal && edges_goal < SLOTS)
            begin
                wait_quiet();
                write_reg(CFG_TIMEOUT, CFG_DATA_W'(end_to));
                gen_to = end_to;
            end
            else if (e % 12 == 0)
            begin
                wait_quiet();
                case ($urandom_range(0, 4))
                    0:       val = 24'hFF_FFFF;
                    1:       val = 24'd0;
                    2:       val = 24'd1;
                    3:       val = 24'd2;
                    default: val = CFG_DATA_W'($urandom_range(3, 50));
                endcase
                write_reg(CFG_TIMEOUT, val);
                gen_to = val[TIMEOUT_W-1:0];
            end
            if ($urandom_range(0, 3) == 0)
                st = $urandom;
            else
                st = gen_prev + $urandom_range(1, 20000);
            push_item(KIND_EDGE, st, $urandom_range(0, 1));
            gen_prev = st;
            counted++;
            if (e < edges_goal)
            begin
                // stay short of the timeout so the capture goes on
                n_ticks = (gen_to <= 1) ? 0 : $urandom_range(0, (gen_to - 1 < 6) ? gen_to - 1 : 6);
                repeat (n_ticks) push_item(KIND_TICK, $urandom, $urandom_range(0, 1));
                counted += n_ticks;
                if ($urandom_range(0, 5) == 0)
                begin
                    push_item(($urandom_range(0, 1) == 1) ? KIND_REPLAY : KIND_NONE,
                              $urandom, $urandom_range(0, 1));
                    counted++;
                end
            end
        end
        // closing item: edge into a full store, or the ticks that run the timer out
        if (edges_goal == SLOTS)
        begin
            push_item(KIND_EDGE, $urandom, $urandom_range(0, 1));
            counted++;
        end
        else
        begin
            repeat ((end_to == 0) ? 1 : end_to) push_item(KIND_TICK, $urandom, $urandom_range(0, 1));
            counted += (end_to == 0) ? 1 : end_to;
        end

        // replays under a range of rates, with ignored edges and ticks between
        phase = 0;
        while (counted < ITEM_TARGET)
        begin
            wait_quiet();
            calm = (counted >= ITEM_TARGET - CALM_ITEMS);
            if (calm)
            begin
                send_gap   = 0;
                recv_stall = 0;
            end
            case (phase % 6)
                0:       val = 24'd0;
                1:       val = 24'hFF_FFFF;
                2:       val = CFG_DATA_W'(RATE_RESET);
                3:       val = 24'd1;
                default: val = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_RATE, val);
            if (phase % 4 == 3)
                write_reg(CFG_TIMEOUT, CFG_DATA_W'($urandom));
            burst = $urandom_range(2, 6);
            for (int j = 0; j < burst; j++)
            begin
                if ($urandom_range(0, 9) < 6)
                    push_item(KIND_REPLAY, $urandom, $urandom_range(0, 1));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       push_item(KIND_EDGE, $urandom, $urandom_range(0, 1));
                        1:       push_item(KIND_TICK, $urandom, $urandom_range(0, 1));
                        default: push_item(KIND_NONE, $urandom, $urandom_range(0, 1));
                    endcase
                end
                counted++;
            end
            phase++;
        end

        // drain and finish
        wait_quiet();
        repeat (TAIL_CYC) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("result items never delivered", results_due.size(), 64'd0);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #(LIMIT_T);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
